### hw/rtl/fqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_pkg
// Shared types, character codes and helpers of the form query decoder.
// ----------------------------------------------------------------------------
package fqd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NUL     = 8'h00;

	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_FIRST = 2'd1,
		ESC_SECOND = 2'd2,
		ESC_UNUSED = 2'd3
	} esc_phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       byte_valid;
		logic       is_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       in_value_part;
		logic       name_done;
		logic       pair_done;
		logic       decode_error;
	} out_word_t;

	typedef struct packed {
		logic       value_mode;
		esc_phase_t escape_phase;
		logic [3:0] high_nibble;
		logic       error_skip;
	} dec_state_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nibble;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok = 1'b1;
			h.nibble = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.ok = 1'b1;
			h.nibble = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.ok = 1'b1;
			h.nibble = 4'(c - 8'h57);
		end
		return h;
	endfunction

	function automatic logic word_at_end(input in_word_t w);
		return w.is_last || (w.byte_valid && w.in_byte == CH_NUL);
	endfunction

endpackage

### hw/rtl/fqd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_in_if / fqd_out_if
// Valid/ready channels carrying raw query words and decoded result words.
// ----------------------------------------------------------------------------
interface fqd_in_if import fqd_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fqd_out_if import fqd_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/form_query_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// form_query_decoder_top
// URL query / form body decoder: splits name=value pairs and decodes escapes.
// ----------------------------------------------------------------------------
// An accepted input word passes through the input register, then the result register.
// Throughput: 1 word per cycle while the sink takes results; the input register and
// result register each hold one word, and ready is high while the input register is empty or can move on.
// Reset: arst_n clears valid flags and decoder state (name part, no escape,
// not skipping); payload registers are not reset.
module form_query_decoder_top import fqd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	fqd_in_if.sink    query,
	fqd_out_if.source decoded
);

	logic       valid_s1;
	in_word_t   word_s1;
	dec_state_t state_q;
	dec_state_t state_nxt;
	out_word_t  res;
	logic       can_load;
	logic       adv;

	// s1 word moves into the result register
	assign adv         = valid_s1 && can_load;
	assign query.ready = !valid_s1 || can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (query.ready) begin
				valid_s1 <= query.valid;
			end
			if (adv) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (query.ready && query.valid) begin
			word_s1 <= query.data;
		end
	end

	fqd_step u_step (
		.st   (state_q),
		.word (word_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	fqd_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (valid_s1),
		.res      (res),
		.can_load (can_load),
		.decoded  (decoded)
	);

	// every end of input leaves the decoder in its restart state
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && word_at_end(word_s1)) |=> (state_q == '0))
		else $error("state not restarted after end of input");

	assert property (@(posedge clk) disable iff (!arst_n)
		(decoded.valid && decoded.data.decode_error) |->
		(!decoded.data.out_valid && !decoded.data.pair_done && !decoded.data.name_done))
		else $error("error word carries data or pair marks");

	assert property (@(posedge clk) disable iff (!arst_n)
		(decoded.valid && decoded.data.name_done) |-> !decoded.data.in_value_part)
		else $error("name_done outside the name part");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.escape_phase != ESC_UNUSED)
		else $error("illegal escape phase");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.error_skip) |-> (state_q.escape_phase == ESC_NONE && state_q.high_nibble == '0))
		else $error("escape left pending while skipping");

endmodule

### hw/rtl/fqd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_step
// Per-word decode: current state and one input word give the result word
// and the next state.
// ----------------------------------------------------------------------------
module fqd_step import fqd_pkg::*; (
	input  dec_state_t st,
	input  in_word_t   word,
	output dec_state_t nxt,
	output out_word_t  res
);

	logic has_char;
	logic at_end;
	logic err;
	hex_t hx;

	assign has_char = word.byte_valid && (word.in_byte != CH_NUL);
	assign at_end   = word_at_end(word);
	assign hx       = hex_decode(word.in_byte);

	always_comb begin
		nxt = st;
		res = '0;
		err = 1'b0;
		if (st.error_skip) begin
			if (at_end) begin
				nxt = '0;
			end
		end else begin
			res.in_value_part = st.value_mode;
			if (has_char) begin
				if (st.escape_phase == ESC_FIRST) begin
					if (!hx.ok) begin
						err = 1'b1;
					end else begin
						nxt.high_nibble = hx.nibble;
						nxt.escape_phase = ESC_SECOND;
					end
				end else if (st.escape_phase == ESC_SECOND) begin
					if (!hx.ok) begin
						err = 1'b1;
					end else begin
						res.out_byte = {st.high_nibble, hx.nibble};
						res.out_valid = 1'b1;
						nxt.escape_phase = ESC_NONE;
						nxt.high_nibble = '0;
					end
				end else if (word.in_byte == CH_PERCENT) begin
					nxt.escape_phase = ESC_FIRST;
				end else if (word.in_byte == CH_PLUS) begin
					res.out_byte = CH_SPACE;
					res.out_valid = 1'b1;
				end else if (!st.value_mode && word.in_byte == CH_EQUALS) begin
					res.name_done = 1'b1;
					nxt.value_mode = 1'b1;
				end else if (st.value_mode && word.in_byte == CH_AMP) begin
					res.pair_done = 1'b1;
					nxt.value_mode = 1'b0;
				end else begin
					res.out_byte = word.in_byte;
					res.out_valid = 1'b1;
				end
			end
			// end of input closes the pair unless an escape is still open
			if (!err && at_end) begin
				if (nxt.escape_phase != ESC_NONE) begin
					err = 1'b1;
				end else begin
					res.pair_done = 1'b1;
					nxt = '0;
				end
			end
			if (err) begin
				res.out_byte = '0;
				res.out_valid = 1'b0;
				res.name_done = 1'b0;
				res.pair_done = 1'b0;
				res.decode_error = 1'b1;
				if (at_end) begin
					nxt = '0;
				end else begin
					nxt.error_skip = 1'b1;
					nxt.escape_phase = ESC_NONE;
					nxt.high_nibble = '0;
				end
			end
		end
	end

endmodule

### hw/rtl/fqd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_out_reg
// Result register: holds one decoded word until the sink takes it.
// ----------------------------------------------------------------------------
module fqd_out_reg import fqd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_word_t res,
	output logic      can_load,
	fqd_out_if.source decoded
);

	logic      valid_s2;
	out_word_t data_s2;

	assign can_load      = !valid_s2 || decoded.ready;
	assign decoded.valid = valid_s2;
	assign decoded.data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_load) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			data_s2 <= res;
		end
	end

endmodule

### dv/fqd_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_decode_checker
// Watches the query and decoded channels of the form query decoder. It keeps
// its own decoder state, works out the result word for every accepted query
// word, and compares each accepted result word with the oldest one waiting.
// ----------------------------------------------------------------------------
module fqd_decode_checker import fqd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	fqd_in_if    query,
	fqd_out_if   decoded,
	output int   fail_count,
	output int   pending
);

	dec_state_t dec;
	out_word_t  expected_words[$];

	function automatic logic hex_value(input logic [7:0] c, output logic [3:0] nib);
		nib = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			nib = c[3:0];
			return 1'b1;
		end
		if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			nib = c[3:0] + 4'd9;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Predicts the result word of one query word and advances the decoder state.
	function automatic out_word_t decode_word(input in_word_t w);
		out_word_t  r;
		logic       has_char;
		logic       at_end;
		logic       ok;
		logic [3:0] nib;
		r = '0;
		has_char = w.byte_valid && (w.in_byte != CH_NUL);
		at_end = w.is_last || (w.byte_valid && (w.in_byte == CH_NUL));
		r.in_value_part = dec.value_mode;
		if (dec.error_skip) begin
			r.in_value_part = 1'b0;
			if (at_end)
				dec = '0;
		end else begin
			if (has_char) begin
				ok = hex_value(w.in_byte, nib);
				case (dec.escape_phase)
				ESC_FIRST: begin
					if (!ok) begin
						r.decode_error = 1'b1;
					end else begin
						dec.high_nibble = nib;
						dec.escape_phase = ESC_SECOND;
					end
				end
				ESC_SECOND: begin
					if (!ok) begin
						r.decode_error = 1'b1;
					end else begin
						r.out_byte = {dec.high_nibble, nib};
						r.out_valid = 1'b1;
						dec.escape_phase = ESC_NONE;
						dec.high_nibble = 4'd0;
					end
				end
				default: begin
					if (w.in_byte == CH_PERCENT) begin
						dec.escape_phase = ESC_FIRST;
					end else if (w.in_byte == CH_PLUS) begin
						r.out_byte = CH_SPACE;
						r.out_valid = 1'b1;
					end else if (!dec.value_mode && w.in_byte == CH_EQUALS) begin
						r.name_done = 1'b1;
						dec.value_mode = 1'b1;
					end else if (dec.value_mode && w.in_byte == CH_AMP) begin
						r.pair_done = 1'b1;
						dec.value_mode = 1'b0;
					end else begin
						r.out_byte = w.in_byte;
						r.out_valid = 1'b1;
					end
				end
				endcase
			end
			if (!r.decode_error && at_end) begin
				// end inside an escape is a truncation, not a pair close
				if (dec.escape_phase != ESC_NONE) begin
					r.decode_error = 1'b1;
				end else begin
					r.pair_done = 1'b1;
					dec = '0;
				end
			end
			if (r.decode_error) begin
				r.out_byte = 8'h00;
				r.out_valid = 1'b0;
				r.name_done = 1'b0;
				r.pair_done = 1'b0;
				if (at_end) begin
					dec = '0;
				end else begin
					dec.error_skip = 1'b1;
					dec.escape_phase = ESC_NONE;
					dec.high_nibble = 4'd0;
				end
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t got;
		out_word_t want;
		if (!arst_n) begin
			expected_words.delete();
			dec = '0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (decoded.valid && decoded.ready) begin
				got = decoded.data;
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected result word", int'(got), 0);
				end else begin
					want = expected_words.pop_front();
					if (got.out_byte != want.out_byte)
						report_mismatch("out_byte", got.out_byte, want.out_byte);
					if (got.out_valid != want.out_valid)
						report_mismatch("out_valid", got.out_valid, want.out_valid);
					if (got.in_value_part != want.in_value_part)
						report_mismatch("in_value_part", got.in_value_part, want.in_value_part);
					if (got.name_done != want.name_done)
						report_mismatch("name_done", got.name_done, want.name_done);
					if (got.pair_done != want.pair_done)
						report_mismatch("pair_done", got.pair_done, want.pair_done);
					if (got.decode_error != want.decode_error)
						report_mismatch("decode_error", got.decode_error, want.decode_error);
				end
			end
			if (query.valid && query.ready)
				expected_words.push_back(decode_word(query.data));
			pending = expected_words.size();
		end
	end

endmodule

### dv/tb_form_query_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_form_query_decoder_top
// Drives directed and random query text into the form query decoder with
// random gaps and output stalls, a long output hold-off and a full drain.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_form_query_decoder_top;
	import fqd_pkg::*;

	localparam int WORD_TARGET = 1850;
	localparam int HOLD_CYCLES = 200;
	localparam int TIMEOUT_NS  = 5_000_000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   words_sent;
	bit   quiet;
	bit   hold_out;

	in_word_t query_text[$];

	fqd_in_if  query_ch();
	fqd_out_if decoded_ch();

	form_query_decoder_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_ch),
		.decoded(decoded_ch)
	);

	fqd_decode_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (query_ch),
		.decoded   (decoded_ch),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#(TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end

	task automatic send_word(input logic [7:0] b, input logic v, input logic l);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			query_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		query_ch.valid <= 1'b1;
		query_ch.data <= '{in_byte: b, byte_valid: v, is_last: l};
		do @(posedge clk); while (!query_ch.ready);
		if (v || l)
			words_sent++;
	endtask

	function automatic void put_word(input logic [7:0] b, input logic v, input logic l);
		query_text.push_back('{in_byte: b, byte_valid: v, is_last: l});
	endfunction

	function automatic void put_char(input logic [7:0] c);
		put_word(c, 1'b1, 1'b0);
	endfunction

	// end on the last char, or with an end-only word when there is none
	function automatic void close_query();
		if (query_text.size() == 0)
			put_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		else
			query_text[query_text.size() - 1].is_last = 1'b1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + 8'(v);
		return ($urandom_range(0, 1) != 0 ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
	endfunction

	function automatic logic [7:0] bad_hex();
		case ($urandom_range(0, 3))
		0: return 8'($urandom_range(8'h67, 8'h7e));
		1: return 8'($urandom_range(8'h47, 8'h60));
		2: return 8'($urandom_range(8'h80, 8'hff));
		default: return 8'($urandom_range(8'h21, 8'h2f));
		endcase
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do begin
			if ($urandom_range(0, 7) == 0)
				c = 8'($urandom_range(8'h80, 8'hff));
			else
				c = 8'($urandom_range(8'h01, 8'h7e));
		end while (c == CH_PERCENT || c == CH_PLUS || c == CH_EQUALS || c == CH_AMP);
		return c;
	endfunction

	function automatic void put_text(input int n);
		int sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 39);
			if (sel < 26) begin
				put_char(plain_char());
			end else if (sel < 30) begin
				put_char(CH_PLUS);
			end else if (sel < 37) begin
				put_char(CH_PERCENT);
				put_char(hex_char(4'($urandom_range(0, 15))));
				put_char(hex_char(4'($urandom_range(0, 15))));
			end else if (sel < 38) begin
				put_char($urandom_range(0, 1) != 0 ? CH_EQUALS : CH_AMP);
			end else begin
				put_char(CH_PERCENT);
				if ($urandom_range(0, 1) != 0)
					put_char(hex_char(4'($urandom_range(0, 15))));
				put_char(bad_hex());
			end
		end
	endfunction

	task automatic flush_query();
		in_word_t w;
		while (query_text.size() > 0) begin
			w = query_text.pop_front();
			if ($urandom_range(0, 19) == 0)
				send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_word(w.in_byte, w.byte_valid, w.is_last);
		end
	endtask

	task automatic send_text(input string s, input bit ends);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
		if (ends)
			close_query();
		flush_query();
	endtask

	task automatic send_query();
		int pairs;
		pairs = $urandom_range(0, 3);
		for (int p = 0; p < pairs; p++) begin
			if (p > 0)
				put_char(CH_AMP);
			put_text($urandom_range(0, 4));
			if ($urandom_range(0, 9) != 0) begin
				put_char(CH_EQUALS);
				put_text($urandom_range(0, 5));
			end
		end
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4: close_query();
		5, 6: put_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		7: put_word(CH_NUL, 1'b1, 1'($urandom_range(0, 1)));
		8: begin
			// input ends inside an escape
			put_char(CH_PERCENT);
			if ($urandom_range(0, 1) != 0)
				put_char(hex_char(4'($urandom_range(0, 15))));
			if ($urandom_range(0, 1) != 0)
				close_query();
			else
				put_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
		default: begin
			put_char(CH_AMP);
			close_query();
		end
		endcase
		flush_query();
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 10))
			send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 3) != 0),
				1'($urandom_range(0, 7) == 0));
	endtask

	task automatic drain();
		query_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		int stall;
		decoded_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 6);
			if (hold_out) begin
				stall = HOLD_CYCLES;
				hold_out = 1'b0;
			end
			if (stall > 0) begin
				decoded_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			decoded_ch.ready <= 1'b1;
			do @(posedge clk); while (!decoded_ch.valid);
		end
	end

	initial begin
		int phase;
		words_sent = 0;
		quiet = 1'b0;
		hold_out = 1'b0;
		arst_n = 1'b0;
		query_ch.valid <= 1'b0;
		query_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("&%4a+==%FF&", 0);
		send_text("%00", 0);
		send_word(8'hA5, 1'b0, 1'b1);
		send_word(8'hFF, 1'b1, 1'b0);
		send_text("=&", 1);
		send_word(8'h00, 1'b0, 1'b0);
		send_text("%4", 0);
		send_word(CH_NUL, 1'b1, 1'b1);
		send_text("%G", 0);
		send_word(8'hFF, 1'b1, 1'b0);
		send_word(8'h3D, 1'b0, 1'b1);
		send_text("%", 1);
		drain();

		phase = 0;
		while (words_sent < WORD_TARGET) begin
			quiet = ($urandom_range(0, 7) == 0);
			// back-to-back words against a held output so the input stalls
			if (phase == 3 || phase == 20) begin
				hold_out = 1'b1;
				quiet = 1'b1;
			end
			repeat ($urandom_range(5, 15)) begin
				if ($urandom_range(0, 11) == 0)
					send_noise();
				else
					send_query();
			end
			if (phase % 5 == 2)
				drain();
			phase++;
		end

		query_ch.valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### files.f
hw/rtl/fqd_pkg.sv
hw/rtl/fqd_if.sv
hw/rtl/fqd_step.sv
hw/rtl/fqd_out_reg.sv
hw/rtl/form_query_decoder_top.sv
dv/fqd_decode_checker.sv
dv/tb_form_query_decoder_top.sv
